// ----- sv/sasc_pkg.sv -----
`timescale 1ns / 1ps

package sasc_pkg;

    localparam int DEPTH     = 1024;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(DEPTH);
    // search bounds run from 0 to DEPTH inclusive
    localparam int SPAN_BITS = ADDR_BITS + 1;
    localparam int CNT_BITS  = 11;
    localparam int CMD_BITS  = 2;
    localparam int POS_BITS  = 10;
    localparam int KEY_BITS  = 32;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_EXACT = 2'd1,
        CMD_CEIL  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic start;
        logic probe;
        logic cmp;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic empty;
        logic exact_hit;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- sv/sasc_in_if.sv -----
`timescale 1ns / 1ps

interface sasc_in_if;
    logic                                valid;
    logic                                ready;
    logic        [sasc_pkg::CMD_BITS-1:0] command;
    logic        [sasc_pkg::POS_BITS-1:0] position;
    logic signed [sasc_pkg::KEY_BITS-1:0] key;

    modport source (output valid, command, position, key, input ready);
    modport sink   (input valid, command, position, key, output ready);
endinterface

// ----- sv/sasc_out_if.sv -----
`timescale 1ns / 1ps

interface sasc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic        [sasc_pkg::POS_BITS-1:0]  match_position;
    logic signed [sasc_pkg::KEY_BITS-1:0]  match_value;

    modport source (output valid, found, match_position, match_value, input ready);
    modport sink   (input valid, found, match_position, match_value, output ready);
endinterface

// ----- sv/sorted_array_search_ceiling_top.sv -----
`timescale 1ns / 1ps
// Sorted-array search with exact and ceiling queries.
// i_in (valid/ready): one transaction carries command, position and key.
//   Load writes key to the store at position and gives no result.
//   Exact search returns found plus the position and value of a hit.
//   Ceiling search returns the first entry at or above key, or not-found.
//   Command 3 is taken and dropped.
// o_out (valid/ready): one transaction per search; not-found gives zeros.
// i_cfg_we/i_cfg_data set element_count, the entries a search covers;
//   write it only while no search is in flight.
// Sequence: a load is written as it is taken and ready stays high. A search
//   probes the store, each probe being a registered store read followed by
//   a compare, until the bounds meet; an exact hit stops probing early.
//   Input ready is low for the whole of a search and returns in the same
//   cycle that the result appears at the output, so a new search is taken
//   only after the last one has produced its result.
// The result sits in an output register; while the receiver stalls, loads
//   and the next search still proceed until a second result is ready.
// Reset (synchronous, active low) clears element_count and the handshake
//   state. The store is not cleared: read only entries already loaded.
module sorted_array_search_ceiling_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sasc_pkg::CNT_BITS-1:0] i_cfg_data,
    sasc_in_if.sink                       i_in,
    sasc_out_if.source                    o_out
);

    sasc_pkg::t_ctrl_cmd cmd;
    sasc_pkg::t_dp_stat  stat;

    // sequencer: idle, probe issue, compare, result hand-off
    sasc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .o_in_ready   (i_in.ready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    // store, search bounds, comparator and output register
    sasc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_command   (i_in.command),
        .i_in_position  (i_in.position),
        .i_in_key       (i_in.key),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_found    (o_out.found),
        .o_out_position (o_out.match_position),
        .o_out_value    (o_out.match_value)
    );

endmodule

// ----- sv/sasc_ctrl.sv -----
`timescale 1ns / 1ps

module sasc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [sasc_pkg::CMD_BITS-1:0] i_in_command,
    output logic                          o_in_ready,
    input  sasc_pkg::t_dp_stat            i_stat,
    output sasc_pkg::t_ctrl_cmd           o_cmd
);

    sasc_pkg::t_state r_state, n_state;
    logic             accept;

    assign accept = i_in_valid && (r_state == sasc_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sasc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sasc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    case (sasc_pkg::t_cmd'(i_in_command))
                        sasc_pkg::CMD_LOAD: o_cmd.load_wr = 1'b1;
                        sasc_pkg::CMD_EXACT, sasc_pkg::CMD_CEIL: begin
                            o_cmd.start = 1'b1;
                            n_state     = sasc_pkg::ST_PROBE;
                        end
                        default: ;  // unused code, dropped
                    endcase
                end
            end
            sasc_pkg::ST_PROBE: begin
                if (i_stat.empty) begin
                    n_state = sasc_pkg::ST_DONE;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = sasc_pkg::ST_CMP;
                end
            end
            sasc_pkg::ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_stat.exact_hit ? sasc_pkg::ST_DONE : sasc_pkg::ST_PROBE;
            end
            sasc_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = sasc_pkg::ST_IDLE;
                end
            end
            default: n_state = sasc_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- sv/sasc_dp.sv -----
`timescale 1ns / 1ps

module sasc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic        [sasc_pkg::CNT_BITS-1:0] i_cfg_data,
    input  logic        [sasc_pkg::CMD_BITS-1:0] i_in_command,
    input  logic        [sasc_pkg::POS_BITS-1:0] i_in_position,
    input  logic signed [sasc_pkg::KEY_BITS-1:0] i_in_key,
    input  sasc_pkg::t_ctrl_cmd                  i_cmd,
    output sasc_pkg::t_dp_stat                   o_stat,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_out_found,
    output logic        [sasc_pkg::POS_BITS-1:0] o_out_position,
    output logic signed [sasc_pkg::KEY_BITS-1:0] o_out_value
);

    localparam int SB = sasc_pkg::SPAN_BITS;
    localparam int AB = sasc_pkg::ADDR_BITS;

    logic [sasc_pkg::WORD_BITS-1:0] r_mem [sasc_pkg::DEPTH];

    logic [sasc_pkg::CNT_BITS-1:0]        r_count;
    logic [SB-1:0]                        r_lo, r_end, r_mid;
    logic                                 r_ceil;
    logic signed [sasc_pkg::KEY_BITS-1:0] r_key;
    logic signed [sasc_pkg::KEY_BITS-1:0] r_rd_data;
    logic                                 r_hit;
    logic [sasc_pkg::POS_BITS-1:0]        r_hit_pos;
    logic signed [sasc_pkg::KEY_BITS-1:0] r_hit_val;
    logic                                 r_out_valid;
    logic                                 r_out_found;
    logic [sasc_pkg::POS_BITS-1:0]        r_out_pos;
    logic signed [sasc_pkg::KEY_BITS-1:0] r_out_val;

    logic [SB-1:0] active_n, span, half, mid;
    logic          eq, gt, ge;

    // count above the store depth covers the whole store
    assign active_n = (r_count > sasc_pkg::CNT_BITS'(sasc_pkg::DEPTH))
                    ? SB'(sasc_pkg::DEPTH) : SB'(r_count);

    // exact search splits [lo, end-1] with the lower midpoint, ceiling splits [lo, end)
    assign span = r_end - r_lo;
    assign half = r_ceil ? (span >> 1) : ((span - SB'(1)) >> 1);
    assign mid  = r_lo + half;

    assign eq = (r_rd_data == r_key);
    assign gt = (r_rd_data >  r_key);
    assign ge = eq || gt;

    assign o_stat.empty     = (r_lo >= r_end);
    assign o_stat.exact_hit = !r_ceil && eq;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem[i_in_position[AB-1:0]] <= i_in_key;
        end
        r_rd_data <= r_mem[mid[AB-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_lo   <= '0;
            r_end  <= active_n;
            r_ceil <= (i_in_command == sasc_pkg::CMD_CEIL);
            r_key  <= i_in_key;
            r_hit  <= 1'b0;
        end
        if (i_cmd.probe) begin
            r_mid <= mid;
        end
        if (i_cmd.cmp) begin
            if (r_ceil) begin
                if (ge) begin
                    r_end     <= r_mid;
                    r_hit     <= 1'b1;
                    r_hit_pos <= sasc_pkg::POS_BITS'(r_mid);
                    r_hit_val <= r_rd_data;
                end else begin
                    r_lo <= r_mid + SB'(1);
                end
            end else if (eq) begin
                r_hit     <= 1'b1;
                r_hit_pos <= sasc_pkg::POS_BITS'(r_mid);
                r_hit_val <= r_rd_data;
            end else if (gt) begin
                r_end <= r_mid;
            end else begin
                r_lo <= r_mid + SB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_found <= r_hit;
            r_out_pos   <= r_hit ? r_hit_pos : '0;
            r_out_val   <= r_hit ? r_hit_val : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_found    = r_out_found;
    assign o_out_position = r_out_pos;
    assign o_out_value    = r_out_val;

endmodule

// ----- sv/sasc_checker.sv -----
`timescale 1ns / 1ps

module sasc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic                                 i_out_found,
    input logic        [sasc_pkg::POS_BITS-1:0] i_out_position,
    input logic signed [sasc_pkg::KEY_BITS-1:0] i_out_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_found) && $stable(i_out_position) && $stable(i_out_value))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_position == '0 && i_out_value == '0)
        else $error("not-found result with non-zero fields");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_busy_before_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a search in flight");

endmodule

bind sorted_array_search_ceiling_top sasc_checker u_sasc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_found    (o_out.found),
    .i_out_position (o_out.match_position),
    .i_out_value    (o_out.match_value)
);

// ----- bench/tb_sorted_array_search_ceiling_top.sv -----
`timescale 1ns / 1ps

module tb_sorted_array_search_ceiling_top;

    // command 3 is taken by the block and dropped
    localparam logic [sasc_pkg::CMD_BITS-1:0] CMD_SPARE = 2'd3;
    localparam int  FILL          = 256;    // entries loaded and searched
    localparam int  DUP_AT        = 100;    // entry repeated by the next one
    localparam int  SETTLE_CYCLES = 40;     // settle gap after each drain
    localparam int  STALL_CYCLES  = 400;    // long receiver hold-off
    localparam int  DRAIN_GUARD   = 20000;
    localparam logic signed [sasc_pkg::KEY_BITS-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [sasc_pkg::KEY_BITS-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [sasc_pkg::CMD_BITS-1:0] command;
        logic [sasc_pkg::POS_BITS-1:0] position;
        logic [sasc_pkg::KEY_BITS-1:0] key;
    } t_query;

    typedef struct packed {
        logic                          found;
        logic [sasc_pkg::POS_BITS-1:0] position;
        logic [sasc_pkg::KEY_BITS-1:0] value;
    } t_hit;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [sasc_pkg::CNT_BITS-1:0] i_cfg_data;

    sasc_in_if  in_ch ();
    sasc_out_if out_ch ();

    sorted_array_search_ceiling_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // mirror of the block, updated as transactions are accepted
    logic signed [sasc_pkg::KEY_BITS-1:0] store_mirror [sasc_pkg::DEPTH];
    int unsigned                          count_mirror;
    // store contents as they will be once everything queued has gone in
    logic signed [sasc_pkg::KEY_BITS-1:0] plan_words [sasc_pkg::DEPTH];

    t_query req_backlog [$];
    t_hit   results_due [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int stall_req     = 0;
    int stall_ack     = 0;
    int stall_left    = 0;

    int errors    = 0;
    int n_loads   = 0;
    int n_exact   = 0;
    int n_ceil    = 0;
    int n_hits    = 0;
    int n_checked = 0;
    int n_cfg     = 0;

    // exact search follows the midpoint probe order; ceiling is a lower bound
    function automatic t_hit search_store(input logic [sasc_pkg::CMD_BITS-1:0] cmd,
                                          input logic signed [sasc_pkg::KEY_BITS-1:0] k);
        t_hit r;
        int   n;
        int   lo;
        int   hi;
        int   mid;
        r  = '0;
        n  = (count_mirror > sasc_pkg::DEPTH) ? sasc_pkg::DEPTH : int'(count_mirror);
        if (cmd == sasc_pkg::CMD_EXACT) begin
            lo = 0;
            hi = n - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (store_mirror[mid] == k) begin
                    r.found    = 1'b1;
                    r.position = mid[sasc_pkg::POS_BITS-1:0];
                    r.value    = store_mirror[mid];
                    return r;
                end
                if (store_mirror[mid] > k) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
        end else begin
            lo = 0;
            hi = n;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (store_mirror[mid] >= k) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            if (lo < n) begin
                r.found    = 1'b1;
                r.position = lo[sasc_pkg::POS_BITS-1:0];
                r.value    = store_mirror[lo];
            end
        end
        return r;
    endfunction

    function automatic void flag_error(input string what, input t_hit exp_r, input t_hit got_r);
        errors++;
        if (errors <= 10) begin
            $display("%0t %s: exp f=%0b p=%0d v=%0d got f=%0b p=%0d v=%0d",
                     $realtime, what, exp_r.found, exp_r.position, $signed(exp_r.value),
                     got_r.found, got_r.position, $signed(got_r.value));
        end
    endfunction

    // sender: holds an offered transaction until taken, predicts on acceptance
    always @(posedge i_clk) begin
        t_query nxt;
        t_hit   exp_r;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.command)
                    sasc_pkg::CMD_LOAD: begin
                        store_mirror[in_ch.position] = in_ch.key;
                        n_loads++;
                    end
                    sasc_pkg::CMD_EXACT, sasc_pkg::CMD_CEIL: begin
                        exp_r = search_store(in_ch.command, in_ch.key);
                        results_due.push_back(exp_r);
                        if (in_ch.command == sasc_pkg::CMD_EXACT) begin
                            n_exact++;
                        end else begin
                            n_ceil++;
                        end
                        if (exp_r.found) begin
                            n_hits++;
                        end
                    end
                    default: ;
                endcase
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (req_backlog.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt            = req_backlog.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.command  <= nxt.command;
                    in_ch.position <= nxt.position;
                    in_ch.key      <= nxt.key;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result against the oldest expectation
    always @(posedge i_clk) begin
        t_hit got_r;
        t_hit exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got_r.found    = out_ch.found;
                got_r.position = out_ch.match_position;
                got_r.value    = out_ch.match_value;
                if (results_due.size() == 0) begin
                    flag_error("unexpected result", '0, got_r);
                end else begin
                    exp_r = results_due.pop_front();
                    n_checked++;
                    if (got_r.found !== exp_r.found || got_r.position !== exp_r.position ||
                        got_r.value !== exp_r.value) begin
                        flag_error("result mismatch", exp_r, got_r);
                    end
                end
            end
            if (stall_req != stall_ack) begin
                stall_ack  = stall_req;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic queue_item(input logic [sasc_pkg::CMD_BITS-1:0] cmd,
                              input logic [sasc_pkg::POS_BITS-1:0] pos,
                              input logic signed [sasc_pkg::KEY_BITS-1:0] k);
        t_query r;
        r.command  = cmd;
        r.position = pos;
        r.key      = k;
        req_backlog.push_back(r);
        if (cmd == sasc_pkg::CMD_LOAD) begin
            plan_words[pos] = k;
        end
    endtask

    // load inside the searched region that keeps it in order
    task automatic queue_ordered_load();
        int     p;
        longint lo_v;
        longint hi_v;
        longint v;
        p    = $urandom_range(FILL - 1);
        lo_v = (p == 0) ? longint'(KEY_MIN) : longint'(plan_words[p-1]);
        hi_v = (p == FILL - 1) ? longint'(KEY_MAX) : longint'(plan_words[p+1]);
        if (hi_v < lo_v) begin
            v = lo_v;
        end else begin
            v = lo_v + ($urandom % (hi_v - lo_v + 1));
        end
        queue_item(sasc_pkg::CMD_LOAD, p[sasc_pkg::POS_BITS-1:0], v[sasc_pkg::KEY_BITS-1:0]);
    endtask

    // mostly keys that are stored or sit next to stored values
    function automatic logic signed [sasc_pkg::KEY_BITS-1:0] pick_key(input int n);
        int sel;
        int idx;
        sel = $urandom_range(99);
        idx = (n > 0) ? $urandom_range(n - 1) : 0;
        if (n > 0 && sel < 40) begin
            return plan_words[idx];
        end
        if (n > 0 && sel < 60) begin
            return $urandom_range(1) ? plan_words[idx] + 1 : plan_words[idx] - 1;
        end
        if (sel < 70) begin
            return $urandom_range(1) ? KEY_MAX : KEY_MIN;
        end
        return $urandom;
    endfunction

    // sender pauses until every expected result is back, then a settle gap
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (req_backlog.size() != 0 || in_ch.valid) begin
            @(negedge i_clk);
        end
        while (results_due.size() != 0 && guard < DRAIN_GUARD) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_count(input int unsigned n);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n[sasc_pkg::CNT_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        count_mirror = n;
        n_cfg++;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        longint cur;
        int     step;
        int     dup_at;
        int     gap_at;
        int     n;
        int     sel;
        int     phase_counts [12];

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.command  = sasc_pkg::CMD_LOAD;
        in_ch.position = '0;
        in_ch.key      = '0;
        out_ch.ready   = 1'b0;
        count_mirror   = 0;
        src_idle_pct   = 13;
        sink_idle_pct  = 52;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // element_count is 0 out of reset: searches read nothing and miss
        queue_item(sasc_pkg::CMD_EXACT, '0, '0);
        queue_item(sasc_pkg::CMD_CEIL, '1, KEY_MIN);
        queue_item(CMD_SPARE, 10'h2aa, 32'h5555_aaaa);
        wait_drained();

        // fill the searched region with an ascending run from min to max, some repeats
        cur = longint'(KEY_MIN);
        for (int i = 0; i < FILL; i++) begin
            if (i == FILL - 1) begin
                cur = longint'(KEY_MAX);
            end
            queue_item(sasc_pkg::CMD_LOAD, i[sasc_pkg::POS_BITS-1:0],
                       cur[sasc_pkg::KEY_BITS-1:0]);
            step = (i == DUP_AT || $urandom_range(9) == 0) ? 0 : $urandom_range(30000000);
            cur  = cur + step;
            if (cur > longint'(KEY_MAX)) begin
                cur = longint'(KEY_MAX);
            end
        end
        wait_drained();

        dup_at = DUP_AT;
        gap_at = 0;
        for (int i = FILL - 2; i >= 0; i--) begin
            if (longint'(plan_words[i+1]) - longint'(plan_words[i]) > 1) begin
                gap_at = i;
            end
        end

        // whole loaded region: ends, a repeated value, a gap between entries
        set_count(FILL);
        queue_item(sasc_pkg::CMD_EXACT, '0, KEY_MIN);
        queue_item(sasc_pkg::CMD_EXACT, '1, KEY_MAX);
        queue_item(sasc_pkg::CMD_EXACT, '0, plan_words[dup_at]);
        queue_item(sasc_pkg::CMD_EXACT, '0, plan_words[gap_at] + 1);
        queue_item(sasc_pkg::CMD_CEIL, '0, KEY_MIN);
        queue_item(sasc_pkg::CMD_CEIL, '0, KEY_MAX);
        queue_item(sasc_pkg::CMD_CEIL, '0, plan_words[dup_at]);
        queue_item(sasc_pkg::CMD_CEIL, '0, plan_words[gap_at] + 1);
        queue_item(CMD_SPARE, '1, KEY_MAX);
        wait_drained();

        // a single entry: ceiling above it misses
        set_count(1);
        queue_item(sasc_pkg::CMD_EXACT, '0, KEY_MIN);
        queue_item(sasc_pkg::CMD_EXACT, '0, 32'sd0);
        queue_item(sasc_pkg::CMD_CEIL, '0, KEY_MIN);
        queue_item(sasc_pkg::CMD_CEIL, '0, 32'sd0);
        wait_drained();

        phase_counts = '{FILL, 0, 2, 3, 0, FILL, 7, 1, 0, 0, FILL, 5};
        phase_counts[4] = $urandom_range(4, 64);
        phase_counts[8] = $urandom_range(1, FILL);
        phase_counts[9] = $urandom_range(8, 64);

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                src_idle_pct  = 52;
                sink_idle_pct = 13;
            end else if (ph == 8) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            n = phase_counts[ph];
            set_count(n);
            for (int j = 0; j < 15; j++) begin
                sel = $urandom_range(99);
                if (sel < 3) begin
                    queue_item(CMD_SPARE, sasc_pkg::POS_BITS'($urandom), $urandom);
                end else if (sel < 5) begin
                    // stray load, may leave the store out of order
                    queue_item(sasc_pkg::CMD_LOAD, sasc_pkg::POS_BITS'($urandom), $urandom);
                end else if (sel < 17) begin
                    queue_ordered_load();
                end else begin
                    queue_item(sel[0] ? sasc_pkg::CMD_EXACT : sasc_pkg::CMD_CEIL,
                               sasc_pkg::POS_BITS'($urandom), pick_key(n));
                end
            end
            wait_drained();
        end

        // receiver holds off while searches keep coming: the block fills and
        // stops taking transactions until the stall ends
        set_count(FILL);
        stall_req++;
        for (int j = 0; j < 40; j++) begin
            if ($urandom_range(4) == 0) begin
                queue_ordered_load();
            end else begin
                queue_item($urandom_range(1) ? sasc_pkg::CMD_EXACT : sasc_pkg::CMD_CEIL,
                           sasc_pkg::POS_BITS'($urandom), pick_key(FILL));
            end
        end
        wait_drained();

        if (results_due.size() != 0) begin
            errors += results_due.size();
            $display("%0d expected results never arrived", results_due.size());
        end
        $display("Covered %0d exact and %0d ceiling searches (%0d found), %0d loads,",
                 n_exact, n_ceil, n_hits, n_loads);
        $display("%0d results checked over %0d element_count settings", n_checked, n_cfg);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
